>>> design/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
// No dependencies.
`default_nettype none
package lobm_pkg;
	localparam int MaxOrders = 256;
	localparam int IdxW = $clog2(MaxOrders);
	localparam int CntW = $clog2(MaxOrders + 1);
	localparam int PriceW = 16;
	localparam logic [39:0] SumMax = 40'hFF_FFFF_FFFF;

	localparam logic [1:0] OP_PLACE = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic side;
		logic [PriceW-1:0] limit_price;
		logic [31:0] amount;
		logic [31:0] target_id;
	} req_t;

	localparam int QDepth = 2;
endpackage
`default_nettype wire

>>> design/lobm_front.sv
// Front part: accepts requests into a two-entry queue.
// Depends on lobm_pkg.
`default_nettype none
module lobm_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire lobm_pkg::req_t in_req,
	output logic q_valid,
	input wire logic q_take,
	output lobm_pkg::req_t q_req
);
	import lobm_pkg::*;
	req_t mem_q [QDepth];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;
	assign in_stall = (cnt_q == 2'(QDepth));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = mem_q[rd_q];
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_take);
		end
	end
endmodule
`default_nettype wire

>>> design/lobm_back.sv
// Back part: runs each request over the order table by sequential scans.
// Depends on lobm_pkg.
`default_nettype none
module lobm_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_take,
	input wire lobm_pkg::req_t q_req,
	output logic out_valid,
	input wire logic out_stall,
	output logic result_valid,
	output logic [31:0] result_id,
	output logic bid_valid,
	output logic [15:0] bid_price,
	output logic [31:0] bid_amount,
	output logic [31:0] bid_id,
	output logic ask_valid,
	output logic [15:0] ask_price,
	output logic [31:0] ask_amount,
	output logic [31:0] ask_id,
	output logic [39:0] bid_total,
	output logic [39:0] ask_total
);
	import lobm_pkg::*;
	localparam logic [3:0] ST_IDLE = 4'd0, ST_FIND = 4'd1, ST_MSCAN = 4'd2,
		ST_FILL = 4'd3, ST_FREE = 4'd4, ST_RPT = 4'd5, ST_OUT = 4'd6, ST_WB = 4'd7;

	logic used_q [MaxOrders];
	logic side_m [MaxOrders];
	logic [PriceW-1:0] price_m [MaxOrders];
	logic [31:0] amt_m [MaxOrders];
	logic [31:0] id_m [MaxOrders];

	logic [3:0] st_q;
	req_t r_q;
	logic [CntW-1:0] i_q;
	logic [31:0] next_id_q, rem_q;
	logic pside_q;
	logic [PriceW-1:0] pprice_q;
	logic found_q;
	logic [IdxW-1:0] best_q, free_q;
	logic free_ok_q;
	logic [PriceW-1:0] bp_q, bestp_q [2];
	logic [31:0] bi_q, ba_q, besti_q [2], besta_q [2];
	logic bv_q [2];
	logic [39:0] sum_q [2];
	// registered table read
	logic rd_used, rd_side;
	logic [PriceW-1:0] rd_price;
	logic [31:0] rd_amt, rd_id;
	logic [IdxW-1:0] ri_q;
	logic rv_q;
	logic [IdxW-1:0] idx;
	assign idx = i_q[IdxW-1:0];

	// write port
	logic we;
	logic [IdxW-1:0] wa;
	logic [31:0] wamt;
	logic wfull;

	always_ff @(posedge clk) begin
		rd_side <= side_m[idx]; rd_price <= price_m[idx];
		rd_amt <= amt_m[idx]; rd_id <= id_m[idx];
		if (we && wfull) begin
			side_m[wa] <= pside_q; price_m[wa] <= pprice_q; id_m[wa] <= next_id_q - 32'd1;
		end
		if (we) amt_m[wa] <= wamt;
	end

	logic better, cand;
	always_comb begin
		cand = rv_q && rd_used && (rd_side != pside_q) &&
			(pside_q ? (rd_price >= pprice_q) : (rd_price <= pprice_q));
		if (!found_q) better = 1'b1;
		else if (rd_price == bp_q) better = rd_id < bi_q;
		else if (pside_q) better = rd_price > bp_q;
		else better = rd_price < bp_q;
	end
	logic rbetter;
	always_comb begin
		if (!bv_q[rd_side]) rbetter = 1'b1;
		else if (rd_price == bestp_q[rd_side]) rbetter = rd_id < besti_q[rd_side];
		else if (rd_side) rbetter = rd_price < bestp_q[rd_side];
		else rbetter = rd_price > bestp_q[rd_side];
	end
	logic [40:0] addsum;
	assign addsum = {1'b0, sum_q[rd_side]} + {9'd0, rd_amt};

	logic last;
	assign last = (i_q == CntW'(MaxOrders));

	always_comb begin
		we = 1'b0; wa = best_q; wamt = rd_amt; wfull = 1'b0;
		if (st_q == ST_FILL) begin
			we = 1'b1; wa = best_q; wamt = ba_q - rem_q;
		end else if (st_q == ST_WB) begin
			we = free_ok_q; wa = free_q; wamt = rem_q; wfull = free_ok_q;
		end else if (st_q == ST_FIND && rv_q && rd_used && !found_q && rd_id == r_q.target_id
			&& r_q.operation == OP_UPDATE && r_q.amount != 32'd0 && r_q.amount < rd_amt
			&& r_q.limit_price == rd_price) begin
			we = 1'b1; wa = ri_q; wamt = r_q.amount;
		end
	end
	assign q_take = (st_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		rd_used <= used_q[idx];
		ri_q <= idx;
	end

	// Read data is valid in the cycle after each address of a running scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_q <= 1'b0;
		else rv_q <= !last && ((st_q inside {ST_FIND, ST_RPT}) ||
			(st_q == ST_MSCAN && rem_q != 32'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; next_id_q <= '0; out_valid <= 1'b0;
			for (int k = 0; k < MaxOrders; k++) used_q[k] <= 1'b0;
			i_q <= '0;
		end else begin
			case (st_q)
			ST_IDLE: if (q_valid) begin
				r_q <= q_req; i_q <= '0; found_q <= 1'b0;
				if (q_req.operation == OP_PLACE) begin
					pside_q <= q_req.side; pprice_q <= q_req.limit_price;
					rem_q <= q_req.amount; result_valid <= 1'b1; result_id <= next_id_q;
					next_id_q <= next_id_q + 32'd1;
					st_q <= ST_MSCAN;
				end else begin
					result_valid <= 1'b0; result_id <= '0; rem_q <= '0;
					if (q_req.operation == OP_CANCEL || q_req.operation == OP_UPDATE)
						st_q <= ST_FIND;
					else st_q <= ST_RPT;
				end
			end
			ST_FIND: begin
				if (!last) i_q <= i_q + CntW'(1);
				if (rv_q && rd_used && !found_q && rd_id == r_q.target_id) begin
					found_q <= 1'b1;
					if (we) begin
						result_valid <= 1'b1; result_id <= r_q.target_id;
					end else begin
						used_q[ri_q] <= 1'b0;
						if (r_q.operation == OP_CANCEL) result_valid <= 1'b1;
						else if (r_q.amount != 32'd0) begin
							result_valid <= 1'b1; result_id <= next_id_q;
							next_id_q <= next_id_q + 32'd1;
							pside_q <= rd_side; pprice_q <= r_q.limit_price;
							rem_q <= r_q.amount;
						end
					end
				end
				// A nonzero remainder marks an update that is placed again.
				if (last && !rv_q) begin
					i_q <= '0; found_q <= 1'b0;
					st_q <= (rem_q != 32'd0) ? ST_MSCAN : ST_RPT;
				end
			end
			ST_MSCAN: begin
				if (rem_q == 32'd0) begin i_q <= '0; st_q <= ST_RPT; end
				else begin
					if (!last) i_q <= i_q + CntW'(1);
					if (cand && better) begin
						found_q <= 1'b1; best_q <= ri_q; bp_q <= rd_price; bi_q <= rd_id;
						ba_q <= rd_amt;
					end
					if (last && !rv_q) begin
						i_q <= '0;
						st_q <= (found_q || (cand && better)) ? ST_FILL : ST_FREE;
					end
				end
			end
			ST_FILL: begin
				found_q <= 1'b0;
				if (rem_q < ba_q) rem_q <= '0;
				else begin rem_q <= rem_q - ba_q; used_q[best_q] <= 1'b0; end
				st_q <= ST_MSCAN;
			end
			ST_FREE: begin
				free_ok_q <= 1'b0;
				for (int k = MaxOrders - 1; k >= 0; k--)
					if (!used_q[k]) begin free_q <= IdxW'(k); free_ok_q <= 1'b1; end
				st_q <= ST_WB;
			end
			ST_WB: begin
				if (free_ok_q) used_q[free_q] <= 1'b1;
				i_q <= '0; st_q <= ST_RPT;
			end
			ST_RPT: begin
				// wait first read before accumulating; reset accumulators at start
				if (i_q == '0 && !rv_q) begin
					bv_q[0] <= 1'b0; bv_q[1] <= 1'b0; sum_q[0] <= '0; sum_q[1] <= '0;
				end
				if (!last) i_q <= i_q + CntW'(1);
				if (rv_q && rd_used) begin
					sum_q[rd_side] <= addsum[40] ? SumMax : addsum[39:0];
					if (rbetter) begin
						bv_q[rd_side] <= 1'b1; bestp_q[rd_side] <= rd_price;
						besti_q[rd_side] <= rd_id; besta_q[rd_side] <= rd_amt;
					end
				end
				if (last && !rv_q) st_q <= ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid) out_valid <= 1'b1;
				else if (!out_stall) begin out_valid <= 1'b0; st_q <= ST_IDLE; end
			end
			default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		bid_valid = bv_q[0]; bid_price = bv_q[0] ? bestp_q[0] : '0;
		bid_amount = bv_q[0] ? besta_q[0] : '0; bid_id = bv_q[0] ? besti_q[0] : '0;
		ask_valid = bv_q[1]; ask_price = bv_q[1] ? bestp_q[1] : '0;
		ask_amount = bv_q[1] ? besta_q[1] : '0; ask_id = bv_q[1] ? besti_q[1] : '0;
		bid_total = sum_q[0]; ask_total = sum_q[1];
	end
endmodule
`default_nettype wire

>>> design/limit_order_book_matcher.sv
// Limit order book matcher top level: request queue plus table engine.
// Scans: a request is worked in sequential table scans: one lookup scan for
// cancel or update, one scan per fill, and a final report scan, so a place that fills
// n orders and rests the rest takes n+2 scans, n+1 when filled up.
// One request is worked at a time; the next starts the cycle after a result is taken.
// Reset (arst_n low) empties the table and clears the id counter at once.
`default_nettype none
module limit_order_book_matcher (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] operation,
	input wire logic side,
	input wire logic [15:0] limit_price,
	input wire logic [31:0] amount,
	input wire logic [31:0] target_id,
	output logic out_valid,
	input wire logic out_stall,
	output logic result_valid,
	output logic [31:0] result_id,
	output logic bid_valid,
	output logic [15:0] bid_price,
	output logic [31:0] bid_amount,
	output logic [31:0] bid_id,
	output logic ask_valid,
	output logic [15:0] ask_price,
	output logic [31:0] ask_amount,
	output logic [31:0] ask_id,
	output logic [39:0] bid_total,
	output logic [39:0] ask_total
);
	import lobm_pkg::*;
	req_t in_req, q_req;
	logic q_valid, q_take;
	// Pack the request for the queue.
	assign in_req = '{operation, side, limit_price, amount, target_id};
	lobm_front u_front (.clk, .arst_n, .in_valid, .in_stall, .in_req,
		.q_valid, .q_take, .q_req);
	lobm_back u_back (.clk, .arst_n, .q_valid, .q_take, .q_req, .out_valid, .out_stall,
		.result_valid, .result_id, .bid_valid, .bid_price, .bid_amount, .bid_id,
		.ask_valid, .ask_price, .ask_amount, .ask_id, .bid_total, .ask_total);
endmodule
`default_nettype wire

>>> design/lobm_checker.sv
// Port-level checker for the limit order book matcher, bound to the top level.
// No package dependency.
`default_nettype none
module lobm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic bid_valid,
	input wire logic [15:0] bid_price,
	input wire logic ask_valid,
	input wire logic [39:0] bid_total,
	input wire logic [39:0] ask_total
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_bid0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bid_valid |-> bid_total == 40'd0) else $error("bid total");
	a_ask0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ask_valid |-> ask_total == 40'd0) else $error("ask total");
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bid_valid |-> bid_price == 16'd0) else $error("bid price");
endmodule
bind limit_order_book_matcher lobm_checker u_chk (.clk, .arst_n, .out_valid,
	.out_stall, .bid_valid, .bid_price, .ask_valid, .bid_total, .ask_total);
`default_nettype wire

>>> tb/tb_limit_order_book_matcher.sv
// Testbench for the limit order book matcher: directed and random requests checked
// against an in-bench model of the book. Depends on lobm_pkg and the matcher RTL.
`default_nettype none
module tb_limit_order_book_matcher;
	timeunit 1ns;
	timeprecision 1ps;
	import lobm_pkg::*;

	// One result of the block, field by field as it appears on the ports.
	typedef struct {
		logic result_valid;
		logic [31:0] result_id;
		logic bid_valid;
		logic [15:0] bid_price;
		logic [31:0] bid_amount;
		logic [31:0] bid_id;
		logic ask_valid;
		logic [15:0] ask_price;
		logic [31:0] ask_amount;
		logic [31:0] ask_id;
		logic [39:0] bid_total;
		logic [39:0] ask_total;
	} book_report_t;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic SIDE_BUY = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = OP_PLACE;
	logic side = SIDE_BUY;
	logic [15:0] limit_price = '0;
	logic [31:0] amount = '0;
	logic [31:0] target_id = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_valid;
	logic [31:0] result_id;
	logic bid_valid;
	logic [15:0] bid_price;
	logic [31:0] bid_amount;
	logic [31:0] bid_id;
	logic ask_valid;
	logic [15:0] ask_price;
	logic [31:0] ask_amount;
	logic [31:0] ask_id;
	logic [39:0] bid_total;
	logic [39:0] ask_total;

	// Model of the order table, updated when each request is accepted.
	bit book_used [MaxOrders];
	logic book_side [MaxOrders];
	logic [15:0] book_price [MaxOrders];
	logic [31:0] book_amount [MaxOrders];
	logic [31:0] book_id [MaxOrders];
	logic [31:0] id_counter = '0;

	book_report_t pending_reports [$];
	int errors = 0;
	// While set, neither side inserts idle cycles.
	bit no_idle = 1'b0;

	always #4 clk = ~clk;

	limit_order_book_matcher uut (.*);

	// Best resting order of one side. When limited, only orders that cross the
	// incoming limit are eligible: asks at or below it, bids at or above it.
	function automatic int best_resting(logic s, bit limited, logic [15:0] lim);
		int b;
		bit better;
		b = -1;
		for (int i = 0; i < MaxOrders; i++) begin
			if (!book_used[i] || book_side[i] != s)
				continue;
			if (limited && s == SIDE_SELL && book_price[i] > lim)
				continue;
			if (limited && s == SIDE_BUY && book_price[i] < lim)
				continue;
			if (b < 0) begin
				b = i;
				continue;
			end
			if (book_price[i] == book_price[b])
				better = book_id[i] < book_id[b];
			else if (s == SIDE_BUY)
				better = book_price[i] > book_price[b];
			else
				better = book_price[i] < book_price[b];
			if (better)
				b = i;
		end
		return b;
	endfunction

	function automatic int locate_order(logic [31:0] id);
		for (int i = 0; i < MaxOrders; i++)
			if (book_used[i] && book_id[i] == id)
				return i;
		return -1;
	endfunction

	// Match against the opposite side, then rest any remainder in the first
	// free slot. The id is consumed even if nothing rests.
	function automatic logic [31:0] match_and_rest(logic s, logic [15:0] lim,
			logic [31:0] qty);
		logic [31:0] id;
		int k;
		id = id_counter;
		id_counter = id_counter + 32'd1;
		while (qty != 0) begin
			k = best_resting(~s, 1'b1, lim);
			if (k < 0)
				break;
			if (qty < book_amount[k]) begin
				book_amount[k] = book_amount[k] - qty;
				qty = '0;
			end else begin
				qty = qty - book_amount[k];
				book_used[k] = 1'b0;
			end
		end
		if (qty != 0) begin
			for (int i = 0; i < MaxOrders; i++) begin
				if (!book_used[i]) begin
					book_used[i] = 1'b1;
					book_side[i] = s;
					book_price[i] = lim;
					book_amount[i] = qty;
					book_id[i] = id;
					break;
				end
			end
		end
		return id;
	endfunction

	// Applies one request to the book and returns the report the block must give.
	function automatic book_report_t apply_request(logic [1:0] op, logic s,
			logic [15:0] lim, logic [31:0] qty, logic [31:0] tid);
		book_report_t r;
		int k;
		logic [63:0] buys, sells;
		logic os;
		r = '{default: '0};
		case (op)
			OP_PLACE: begin
				r.result_id = match_and_rest(s, lim, qty);
				r.result_valid = 1'b1;
			end
			OP_CANCEL: begin
				k = locate_order(tid);
				if (k >= 0) begin
					book_used[k] = 1'b0;
					r.result_valid = 1'b1;
				end
			end
			OP_UPDATE: begin
				k = locate_order(tid);
				if (k >= 0) begin
					if (qty > 0 && qty < book_amount[k] && lim == book_price[k]) begin
						// Shrink in place: keeps id and time priority.
						book_amount[k] = qty;
						r.result_valid = 1'b1;
						r.result_id = tid;
					end else begin
						os = book_side[k];
						book_used[k] = 1'b0;
						if (qty > 0) begin
							r.result_id = match_and_rest(os, lim, qty);
							r.result_valid = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		buys = '0;
		sells = '0;
		for (int i = 0; i < MaxOrders; i++) begin
			if (!book_used[i])
				continue;
			if (book_side[i] == SIDE_BUY)
				buys += book_amount[i];
			else
				sells += book_amount[i];
		end
		r.bid_total = buys > SumMax ? SumMax : buys[39:0];
		r.ask_total = sells > SumMax ? SumMax : sells[39:0];
		k = best_resting(SIDE_BUY, 1'b0, '0);
		if (k >= 0) begin
			r.bid_valid = 1'b1;
			r.bid_price = book_price[k];
			r.bid_amount = book_amount[k];
			r.bid_id = book_id[k];
		end
		k = best_resting(SIDE_SELL, 1'b0, '0);
		if (k >= 0) begin
			r.ask_valid = 1'b1;
			r.ask_price = book_price[k];
			r.ask_amount = book_amount[k];
			r.ask_id = book_id[k];
		end
		return r;
	endfunction

	function automatic int live_orders();
		int n;
		n = 0;
		for (int i = 0; i < MaxOrders; i++)
			n += book_used[i];
		return n;
	endfunction

	// Table slot of a random resting order, or -1 when the book is empty.
	function automatic int pick_resting();
		int slots [$];
		for (int i = 0; i < MaxOrders; i++)
			if (book_used[i])
				slots.push_back(i);
		if (slots.size() == 0)
			return -1;
		return slots[$urandom_range(0, slots.size() - 1)];
	endfunction

	// Drives one request, holds it until accepted, then updates the book model
	// and queues the expected report. Called at a rising edge.
	task automatic send_request(logic [1:0] op, logic s, logic [15:0] lim,
			logic [31:0] qty, logic [31:0] tid);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation <= op;
		side <= s;
		limit_price <= lim;
		amount <= qty;
		target_id <= tid;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		pending_reports.push_back(apply_request(op, s, lim, qty, tid));
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// The receiving side stalls for a random number of cycles before each report.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 4);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	// Each accepted report is compared with the oldest expectation.
	always @(posedge clk) begin
		book_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected report", result_id, '0);
			end else begin
				want = pending_reports[0];
				pending_reports.delete(0);
				check_field("result_valid", result_valid, want.result_valid);
				check_field("result_id", result_id, want.result_id);
				check_field("bid_valid", bid_valid, want.bid_valid);
				check_field("bid_price", bid_price, want.bid_price);
				check_field("bid_amount", bid_amount, want.bid_amount);
				check_field("bid_id", bid_id, want.bid_id);
				check_field("ask_valid", ask_valid, want.ask_valid);
				check_field("ask_price", ask_price, want.ask_price);
				check_field("ask_amount", ask_amount, want.ask_amount);
				check_field("ask_id", ask_id, want.ask_id);
				check_field("bid_total", bid_total, want.bid_total);
				check_field("ask_total", ask_total, want.ask_total);
			end
		end
	end

	// Edge cases of each operation, in a sequence whose ids are known in advance.
	task automatic test_directed_operations();
		send_request(OP_PLACE, SIDE_BUY, 16'd500, 32'd0, '0);           // zero amount, id 0
		send_request(OP_PLACE, SIDE_BUY, 16'hFFFF, 32'hFFFF_FFFF, '0);   // id 1, max fields
		send_request(OP_PLACE, SIDE_BUY, 16'd100, 32'd10, '0);           // id 2
		send_request(OP_PLACE, SIDE_BUY, 16'd100, 32'd20, '0);           // id 3, same level
		send_request(OP_PLACE, SIDE_SELL, 16'd0, 32'd5, '0);             // partial fill of id 1
		send_request(OP_PLACE, SIDE_SELL, 16'd200, 32'd7, '0);           // id 5, fills against id 1
		send_request(OP_PLACE, SIDE_SELL, 16'hFFFF, 32'd3, '0);          // id 6, fills against id 1
		send_request(OP_PLACE, SIDE_BUY, 16'd200, 32'd7, '0);            // id 7 rests
		send_request(OP_UPDATE, SIDE_SELL, 16'd100, 32'd4, 32'd3);       // shrink in place
		send_request(OP_UPDATE, SIDE_BUY, 16'd100, 32'd15, 32'd2);       // larger: re-placed
		send_request(OP_UPDATE, SIDE_SELL, 16'd90, 32'd4, 32'd3);        // new price: re-placed
		send_request(OP_UPDATE, SIDE_BUY, 16'd100, 32'd0, 32'd6);        // zero amount, id 6 not in book
		send_request(OP_UPDATE, SIDE_BUY, 16'd100, 32'd5, 32'hFFFF_FFFF);// unknown id
		send_request(OP_CANCEL, SIDE_SELL, 16'hFFFF, 32'hFFFF_FFFF, 32'd1);
		send_request(OP_CANCEL, SIDE_BUY, '0, '0, 32'd1);                // already gone
		send_request(OP_NONE, SIDE_SELL, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_PLACE, SIDE_SELL, 16'd0, 32'hFFFF_FFFF, '0);      // sweeps all bids
		send_request(OP_PLACE, SIDE_BUY, 16'hFFFF, 32'hFFFF_FFFF, '0);   // sweeps all asks
		send_request(OP_CANCEL, SIDE_BUY, '0, '0, id_counter - 32'd1);
	endtask

	// Fill every slot, overflow once, then trade large orders against the full book.
	task automatic test_table_full();
		for (int i = 0; i < MaxOrders; i++)
			send_request(OP_PLACE, SIDE_BUY, 16'(300 + i % 4), 32'hFFFF_0000 + 32'(i), '0);
		send_request(OP_PLACE, SIDE_BUY, 16'd300, 32'd9, '0);            // remainder dropped
		send_request(OP_PLACE, SIDE_SELL, 16'd301, 32'd1, '0);           // partial fill of one bid
		send_request(OP_PLACE, SIDE_SELL, 16'd0, 32'hFFFF_FFFF, '0);
		send_request(OP_PLACE, SIDE_SELL, 16'd0, 32'hFFFF_FFFF, '0);
		send_request(OP_PLACE, SIDE_BUY, 16'hFFFF, 32'hFFFF_FFFF, '0);
		send_request(OP_PLACE, SIDE_BUY, 16'hFFFF, 32'hFFFF_FFFF, '0);
	endtask

	// Random trading around a narrow price band so orders cross and fill often;
	// cancels and updates mostly hit live orders, with some noise mixed in.
	task automatic test_random_book();
		int pick, k;
		logic s;
		logic [15:0] lim;
		logic [31:0] qty;
		for (int n = 0; n < 560; n++) begin
			no_idle = (n % 100) >= 70;
			pick = $urandom_range(0, 99);
			if (live_orders() > 60 && pick < 45)
				pick = 50;
			k = pick_resting();
			s = 1'($urandom_range(0, 1));
			lim = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1000, 1015));
			qty = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 60));
			if (pick < 45 || k < 0) begin
				send_request(OP_PLACE, s, lim, qty, $urandom);
			end else if (pick < 65) begin
				send_request(OP_CANCEL, s, lim, qty, book_id[k]);
			end else if (pick < 75 && book_amount[k] > 1) begin
				send_request(OP_UPDATE, s, book_price[k],
					$urandom_range(1, book_amount[k] - 1), book_id[k]);
			end else if (pick < 80) begin
				send_request(OP_UPDATE, s, book_price[k], book_amount[k], book_id[k]);
			end else if (pick < 85) begin
				send_request(OP_UPDATE, s, lim, 32'd0, book_id[k]);
			end else if (pick < 92) begin
				send_request(OP_UPDATE, s, lim, qty, book_id[k]);
			end else if (pick < 97) begin
				send_request(($urandom_range(0, 1) != 0) ? OP_CANCEL : OP_UPDATE,
					s, 16'($urandom), $urandom, $urandom);
			end else begin
				send_request(OP_NONE, s, 16'($urandom), $urandom, $urandom);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_operations();
		test_table_full();
		test_random_book();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		// A request can take several table scans; let any stray report show up.
		repeat (2000) @(posedge clk);
		if (errors == 0)
			$display("tb_limit_order_book_matcher OK");
		else
			$display("tb_limit_order_book_matcher NOT OK");
		$finish;
	end

	// Watchdog: the slowest legal run is well under this.
	initial begin
		#400ms;
		$display("tb_limit_order_book_matcher NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

>>> limit_order_book_matcher.f
design/lobm_pkg.sv
design/lobm_front.sv
design/lobm_back.sv
design/limit_order_book_matcher.sv
design/lobm_checker.sv
tb/tb_limit_order_book_matcher.sv
